@@ src/tadc_pkg.sv @@
package tadc_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_COMMAND_X       = 2'd0;
    localparam logic [1:0] REG_COMMAND_Y       = 2'd1;
    localparam logic [1:0] REG_TWELVE_BIT_MODE = 2'd2;
    localparam logic [1:0] REG_SETTLE_TICKS    = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Register reset values
    localparam logic [7:0]  COMMAND_X_RESET    = 8'h90;
    localparam logic [7:0]  COMMAND_Y_RESET    = 8'hD0;
    localparam logic        TWELVE_BIT_RESET   = 1'b1;
    localparam logic [15:0] SETTLE_TICKS_RESET = 16'd1000;

    // Frame geometry
    localparam int          CMD_W          = 8;
    localparam int          SAMPLE_W       = 12;
    localparam int          BIT_COUNT_W    = 4;
    localparam logic [3:0]  CMD_BITS       = 4'd8;
    localparam logic [3:0]  READ_LEN_LONG  = 4'd12;
    localparam logic [3:0]  READ_LEN_SHORT = 4'd8;

endpackage

@@ src/touch_adc_spi_averager_unit.sv @@
// Latency: the result beat for an accepted tick is presented on the next cycle.
// Throughput: one tick per cycle, set by the single register stage that holds
// the sequencer state and the output beat; a tick is taken whenever the
// output register is empty or being emptied.
// Reset (rst_n low, asynchronous): sequencer idle, chip select high, clock and
// data low, averages zero, configuration registers at their default values.
module touch_adc_spi_averager_unit #(
    parameter int AVERAGE_LOG2 = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Configuration write port
    input  logic                                cfg_we,
    input  logic [tadc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tadc_pkg::CFG_DATA_W-1:0]     cfg_data,

    // Tick input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                start_req,
    input  logic                                data_in_pin,

    // Result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                chip_select_n,
    output logic                                serial_clock,
    output logic                                data_out_pin,
    output logic                                busy_res,
    output logic                                done_res,
    output logic [tadc_pkg::SAMPLE_W-1:0]       x_average,
    output logic [tadc_pkg::SAMPLE_W-1:0]       y_average
);

    // Sums are wide enough for 2^AVERAGE_LOG2 full-scale samples; the frame
    // counter covers X and Y frames, 2 * 2^AVERAGE_LOG2 in all.
    localparam int SUM_W = tadc_pkg::SAMPLE_W + AVERAGE_LOG2;
    localparam int FRAME_W = AVERAGE_LOG2 + 1;
    localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'((2 << AVERAGE_LOG2) - 1);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_SETTLE   = 4'd1,
        PH_SELECT   = 4'd2,
        PH_CMD_LOW  = 4'd3,
        PH_CMD_HIGH = 4'd4,
        PH_BUSY_A   = 4'd5,
        PH_BUSY_B   = 4'd6,
        PH_BUSY_C   = 4'd7,
        PH_BUSY_D   = 4'd8,
        PH_RD_HIGH  = 4'd9,
        PH_RD_LOW   = 4'd10,
        PH_RD_TAIL  = 4'd11,
        PH_END      = 4'd12
    } phase_t;

    // Configuration registers
    logic [tadc_pkg::CMD_W-1:0]      command_x_reg;
    logic [tadc_pkg::CMD_W-1:0]      command_y_reg;
    logic                            twelve_bit_mode_reg;
    logic [15:0]                     settle_ticks_reg;

    // Sequencer state
    phase_t                          phase_reg, phase_next;
    logic [15:0]                     wait_count_reg, wait_count_next;
    logic [tadc_pkg::BIT_COUNT_W-1:0] bit_count_reg, bit_count_next;
    logic [FRAME_W-1:0]              frame_count_reg, frame_count_next;
    logic [tadc_pkg::CMD_W-1:0]      command_shift_reg, command_shift_next;
    logic [tadc_pkg::SAMPLE_W-1:0]   read_shift_reg, read_shift_next;
    logic [SUM_W-1:0]                sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]                sum_y_reg, sum_y_next;

    // Pin levels and averages double as the output beat: they change only
    // when a tick is accepted, which needs the output register free.
    logic [tadc_pkg::SAMPLE_W-1:0]   x_hold_reg, x_hold_next;
    logic [tadc_pkg::SAMPLE_W-1:0]   y_hold_reg, y_hold_next;
    logic                            pin_cs_reg, pin_cs_next;
    logic                            pin_clk_reg, pin_clk_next;
    logic                            pin_dout_reg, pin_dout_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic                            out_valid_reg;

    logic                            in_accept;
    logic [tadc_pkg::BIT_COUNT_W-1:0] read_len;

    // Stall the input only while a beat is parked and the sink holds it off
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    assign read_len = twelve_bit_mode_reg ? tadc_pkg::READ_LEN_LONG
                                          : tadc_pkg::READ_LEN_SHORT;

    // Sequencer: one tick of the bit-banged serial timing per accepted beat
    always_comb
    begin
        phase_next         = phase_reg;
        wait_count_next    = wait_count_reg;
        bit_count_next     = bit_count_reg;
        frame_count_next   = frame_count_reg;
        command_shift_next = command_shift_reg;
        read_shift_next    = read_shift_reg;
        sum_x_next         = sum_x_reg;
        sum_y_next         = sum_y_reg;
        x_hold_next        = x_hold_reg;
        y_hold_next        = y_hold_reg;
        pin_cs_next        = pin_cs_reg;
        pin_clk_next       = pin_clk_reg;
        pin_dout_next      = pin_dout_reg;
        busy_next          = 1'b1;
        done_next          = 1'b0;

        unique case (phase_reg)
            PH_SETTLE:
            begin
                pin_cs_next     = 1'b1;
                pin_clk_next    = 1'b0;
                wait_count_next = wait_count_reg - 16'd1;
                if (wait_count_next == 16'd0)
                begin
                    phase_next = PH_SELECT;
                end
            end
            PH_SELECT:
            begin
                // Drop chip select and latch the command for this frame
                pin_cs_next        = 1'b0;
                pin_clk_next       = 1'b0;
                command_shift_next = frame_count_reg[0] ? command_y_reg : command_x_reg;
                read_shift_next    = '0;
                bit_count_next     = '0;
                phase_next         = PH_CMD_LOW;
            end
            PH_CMD_LOW:
            begin
                pin_clk_next  = 1'b0;
                pin_dout_next = command_shift_reg[tadc_pkg::CMD_W-1];
                phase_next    = PH_CMD_HIGH;
            end
            PH_CMD_HIGH:
            begin
                pin_clk_next       = 1'b1;
                command_shift_next = {command_shift_reg[tadc_pkg::CMD_W-2:0], 1'b0};
                bit_count_next     = bit_count_reg + 1'b1;
                phase_next         = (bit_count_next >= tadc_pkg::CMD_BITS) ? PH_BUSY_A
                                                                            : PH_CMD_LOW;
            end
            PH_BUSY_A:
            begin
                pin_clk_next = 1'b0;
                phase_next   = PH_BUSY_B;
            end
            PH_BUSY_B:
            begin
                pin_clk_next = 1'b1;
                phase_next   = PH_BUSY_C;
            end
            PH_BUSY_C:
            begin
                pin_clk_next = 1'b0;
                phase_next   = PH_BUSY_D;
            end
            PH_BUSY_D:
            begin
                pin_clk_next   = 1'b0;
                bit_count_next = '0;
                phase_next     = PH_RD_HIGH;
            end
            PH_RD_HIGH:
            begin
                pin_clk_next = 1'b1;
                phase_next   = PH_RD_LOW;
            end
            PH_RD_LOW:
            begin
                // Sample the converter output after the falling edge
                pin_clk_next    = 1'b0;
                read_shift_next = {read_shift_reg[tadc_pkg::SAMPLE_W-2:0], data_in_pin};
                bit_count_next  = bit_count_reg + 1'b1;
                phase_next      = (bit_count_next >= read_len) ? PH_RD_TAIL : PH_RD_HIGH;
            end
            PH_RD_TAIL:
            begin
                pin_clk_next = 1'b1;
                phase_next   = PH_END;
            end
            PH_END:
            begin
                pin_cs_next  = 1'b1;
                pin_clk_next = 1'b0;
                if (frame_count_reg[0])
                begin
                    sum_y_next = sum_y_reg + SUM_W'(read_shift_reg);
                end
                else
                begin
                    sum_x_next = sum_x_reg + SUM_W'(read_shift_reg);
                end
                if (frame_count_reg == FRAME_LAST)
                begin
                    x_hold_next      = sum_x_next[AVERAGE_LOG2 +: tadc_pkg::SAMPLE_W];
                    y_hold_next      = sum_y_next[AVERAGE_LOG2 +: tadc_pkg::SAMPLE_W];
                    done_next        = 1'b1;
                    frame_count_next = '0;
                    phase_next       = PH_IDLE;
                end
                else
                begin
                    frame_count_next = frame_count_reg + 1'b1;
                    phase_next       = PH_SELECT;
                end
            end
            default:
            begin
                // Idle, and any unused phase code behaves the same
                phase_next   = PH_IDLE;
                pin_cs_next  = 1'b1;
                pin_clk_next = 1'b0;
                if (start_req)
                begin
                    sum_x_next       = '0;
                    sum_y_next       = '0;
                    frame_count_next = '0;
                    bit_count_next   = '0;
                    wait_count_next  = settle_ticks_reg;
                    phase_next       = (settle_ticks_reg == 16'd0) ? PH_SELECT : PH_SETTLE;
                end
                else
                begin
                    busy_next = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_x_reg       <= tadc_pkg::COMMAND_X_RESET;
            command_y_reg       <= tadc_pkg::COMMAND_Y_RESET;
            twelve_bit_mode_reg <= tadc_pkg::TWELVE_BIT_RESET;
            settle_ticks_reg    <= tadc_pkg::SETTLE_TICKS_RESET;
            phase_reg           <= PH_IDLE;
            wait_count_reg      <= '0;
            bit_count_reg       <= '0;
            frame_count_reg     <= '0;
            command_shift_reg   <= '0;
            read_shift_reg      <= '0;
            sum_x_reg           <= '0;
            sum_y_reg           <= '0;
            x_hold_reg          <= '0;
            y_hold_reg          <= '0;
            pin_cs_reg          <= 1'b1;
            pin_clk_reg         <= 1'b0;
            pin_dout_reg        <= 1'b0;
            busy_reg            <= 1'b0;
            done_reg            <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tadc_pkg::REG_COMMAND_X:
                        command_x_reg <= cfg_data[tadc_pkg::CMD_W-1:0];
                    tadc_pkg::REG_COMMAND_Y:
                        command_y_reg <= cfg_data[tadc_pkg::CMD_W-1:0];
                    tadc_pkg::REG_TWELVE_BIT_MODE:
                        twelve_bit_mode_reg <= cfg_data[0];
                    tadc_pkg::REG_SETTLE_TICKS:
                        settle_ticks_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (in_accept)
            begin
                // Advance the sequencer and load the output beat together
                phase_reg         <= phase_next;
                wait_count_reg    <= wait_count_next;
                bit_count_reg     <= bit_count_next;
                frame_count_reg   <= frame_count_next;
                command_shift_reg <= command_shift_next;
                read_shift_reg    <= read_shift_next;
                sum_x_reg         <= sum_x_next;
                sum_y_reg         <= sum_y_next;
                x_hold_reg        <= x_hold_next;
                y_hold_reg        <= y_hold_next;
                pin_cs_reg        <= pin_cs_next;
                pin_clk_reg       <= pin_clk_next;
                pin_dout_reg      <= pin_dout_next;
                busy_reg          <= busy_next;
                done_reg          <= done_next;
                out_valid_reg     <= 1'b1;
            end
            else if (!out_stall)
            begin
                // Beat taken with nothing new behind it
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign chip_select_n = pin_cs_reg;
    assign serial_clock  = pin_clk_reg;
    assign data_out_pin  = pin_dout_reg;
    assign busy_res      = busy_reg;
    assign done_res      = done_reg;
    assign x_average     = x_hold_reg;
    assign y_average     = y_hold_reg;

endmodule

@@ tb/sv/touch_adc_spi_averager_unit_test.sv @@
`timescale 1ns / 100ps

module touch_adc_spi_averager_unit_test;

    // Widths taken from the package
    localparam int SAMPLE_W    = tadc_pkg::SAMPLE_W;
    localparam int CFG_INDEX_W = tadc_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = tadc_pkg::CFG_DATA_W;

    // Averaging depth, passed to the block so the model and the RTL agree
    localparam int AVG_LOG2 = 3;
    // Width of the X and Y sums
    localparam int ACC_W = SAMPLE_W + AVG_LOG2;
    // X and Y frames per measurement
    localparam int FRAMES = 2 << AVG_LOG2;
    // Fixed ticks in a frame besides the read bits: select, 16 command ticks,
    // 4 busy-clock ticks, trailing clock high and deselect
    localparam int FRAME_FIXED_TICKS = 23;
    // Cycles of the receiver's long hold-off
    localparam int LONG_HOLD = 300;
    // Run limit in clock cycles, several times the slowest legal run
    localparam int CYCLE_LIMIT = 200000;

    // Sequencer phases of the serial readout
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_SETTLE,
        SEQ_SELECT,
        SEQ_CMD_LO,
        SEQ_CMD_HI,
        SEQ_TURN_A,
        SEQ_TURN_B,
        SEQ_TURN_C,
        SEQ_TURN_D,
        SEQ_RD_HI,
        SEQ_RD_LO,
        SEQ_RD_TAIL,
        SEQ_DESELECT
    } seq_phase_t;

    // How the converter's data pin is filled during a measurement
    typedef enum logic [1:0] {
        DIN_RANDOM,
        DIN_ONES,
        DIN_ZEROS
    } din_fill_t;

    // One timing tick offered to the block
    typedef struct packed {
        logic start;
        logic din;
    } tick_t;

    // One result beat: pin levels, status and held averages
    typedef struct packed {
        logic                cs_n;
        logic                sck;
        logic                mosi;
        logic                busy;
        logic                done;
        logic [SAMPLE_W-1:0] x_avg;
        logic [SAMPLE_W-1:0] y_avg;
    } pin_beat_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                start_req = 1'b0;
    logic                data_in_pin = 1'b0;

    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                chip_select_n;
    logic                serial_clock;
    logic                data_out_pin;
    logic                busy_res;
    logic                done_res;
    logic [SAMPLE_W-1:0] x_average;
    logic [SAMPLE_W-1:0] y_average;

    always #4 clk = ~clk;

    touch_adc_spi_averager_unit #(
        .AVERAGE_LOG2(AVG_LOG2)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_req    (start_req),
        .data_in_pin  (data_in_pin),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .chip_select_n(chip_select_n),
        .serial_clock (serial_clock),
        .data_out_pin (data_out_pin),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .x_average    (x_average),
        .y_average    (y_average)
    );

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    tick_t     pending_ticks[$];   // ticks waiting for the driver
    pin_beat_t expected_beats[$];  // predicted beats, oldest first

    int  ticks_queued = 0;    // ticks handed to the driver so far
    int  beats_seen = 0;      // result beats taken by the receiver
    int  fail_count = 0;
    int  cycle_count = 0;

    // Idling limits per side, 0 gives a stretch with no gaps
    int  send_gap_max = 7;
    int  recv_gap_max = 7;

    // Bump to ask the receiver for one long hold-off
    int  hold_token = 0;

    // Handshake outcomes of the last rising edge, read at the falling edge
    bit  in_taken = 1'b0;
    bit  out_taken = 1'b0;

    // ------------------------------------------------------------------
    // Readout model: configuration copy and sequencer state
    // ------------------------------------------------------------------
    logic [7:0]          cmd_x_cfg;
    logic [7:0]          cmd_y_cfg;
    logic                long_read_cfg;
    logic [15:0]         settle_cfg;

    seq_phase_t          seq_state;
    logic [15:0]         settle_left;
    logic [3:0]          bits_done;
    logic [4:0]          frame_idx;
    logic [7:0]          cmd_sr;
    logic [SAMPLE_W-1:0] rd_sr;
    logic [ACC_W-1:0]    acc_x;
    logic [ACC_W-1:0]    acc_y;
    logic [SAMPLE_W-1:0] avg_x;
    logic [SAMPLE_W-1:0] avg_y;
    logic                pin_cs_n;
    logic                pin_sck;
    logic                pin_mosi;

    // Put the model in its post-reset state
    task automatic reset_readout_model();
        cmd_x_cfg     = tadc_pkg::COMMAND_X_RESET;
        cmd_y_cfg     = tadc_pkg::COMMAND_Y_RESET;
        long_read_cfg = tadc_pkg::TWELVE_BIT_RESET;
        settle_cfg    = tadc_pkg::SETTLE_TICKS_RESET;
        seq_state     = SEQ_IDLE;
        settle_left   = '0;
        bits_done     = '0;
        frame_idx     = '0;
        cmd_sr        = '0;
        rd_sr         = '0;
        acc_x         = '0;
        acc_y         = '0;
        avg_x         = '0;
        avg_y         = '0;
        pin_cs_n      = 1'b1;
        pin_sck       = 1'b0;
        pin_mosi      = 1'b0;
    endtask

    // Advance the readout by one tick and return the beat it produces
    task automatic step_readout(input logic start, input logic din,
                                output pin_beat_t beat);
        logic [3:0] read_len;
        logic       busy;
        logic       done;
        read_len = long_read_cfg ? tadc_pkg::READ_LEN_LONG : tadc_pkg::READ_LEN_SHORT;
        busy = 1'b1;
        done = 1'b0;
        case (seq_state)
            SEQ_SETTLE:
            begin
                pin_cs_n = 1'b1;
                pin_sck = 1'b0;
                settle_left = settle_left - 16'd1;
                if (settle_left == 16'd0)
                    seq_state = SEQ_SELECT;
            end
            SEQ_SELECT:
            begin
                // Latch this frame's command: odd frames convert Y
                pin_cs_n = 1'b0;
                pin_sck = 1'b0;
                cmd_sr = frame_idx[0] ? cmd_y_cfg : cmd_x_cfg;
                rd_sr = '0;
                bits_done = '0;
                seq_state = SEQ_CMD_LO;
            end
            SEQ_CMD_LO:
            begin
                pin_sck = 1'b0;
                pin_mosi = cmd_sr[7];
                seq_state = SEQ_CMD_HI;
            end
            SEQ_CMD_HI:
            begin
                pin_sck = 1'b1;
                cmd_sr = {cmd_sr[6:0], 1'b0};
                bits_done = bits_done + 4'd1;
                seq_state = (bits_done >= tadc_pkg::CMD_BITS) ? SEQ_TURN_A : SEQ_CMD_LO;
            end
            SEQ_TURN_A:
            begin
                pin_sck = 1'b0;
                seq_state = SEQ_TURN_B;
            end
            SEQ_TURN_B:
            begin
                pin_sck = 1'b1;
                seq_state = SEQ_TURN_C;
            end
            SEQ_TURN_C:
            begin
                pin_sck = 1'b0;
                seq_state = SEQ_TURN_D;
            end
            SEQ_TURN_D:
            begin
                pin_sck = 1'b0;
                bits_done = '0;
                seq_state = SEQ_RD_HI;
            end
            SEQ_RD_HI:
            begin
                pin_sck = 1'b1;
                seq_state = SEQ_RD_LO;
            end
            SEQ_RD_LO:
            begin
                // Sample the data pin after the falling edge, MSB first
                pin_sck = 1'b0;
                rd_sr = {rd_sr[SAMPLE_W-2:0], din};
                bits_done = bits_done + 4'd1;
                seq_state = (bits_done >= read_len) ? SEQ_RD_TAIL : SEQ_RD_HI;
            end
            SEQ_RD_TAIL:
            begin
                pin_sck = 1'b1;
                seq_state = SEQ_DESELECT;
            end
            SEQ_DESELECT:
            begin
                pin_cs_n = 1'b1;
                pin_sck = 1'b0;
                if (frame_idx[0])
                    acc_y = acc_y + ACC_W'(rd_sr);
                else
                    acc_x = acc_x + ACC_W'(rd_sr);
                if (int'(frame_idx) + 1 >= FRAMES)
                begin
                    avg_x = SAMPLE_W'(acc_x >> AVG_LOG2);
                    avg_y = SAMPLE_W'(acc_y >> AVG_LOG2);
                    done = 1'b1;
                    frame_idx = '0;
                    seq_state = SEQ_IDLE;
                end
                else
                begin
                    frame_idx = frame_idx + 5'd1;
                    seq_state = SEQ_SELECT;
                end
            end
            default:
            begin
                // Idle: a start request opens a new measurement
                seq_state = SEQ_IDLE;
                pin_cs_n = 1'b1;
                pin_sck = 1'b0;
                if (start)
                begin
                    acc_x = '0;
                    acc_y = '0;
                    frame_idx = '0;
                    bits_done = '0;
                    settle_left = settle_cfg;
                    seq_state = (settle_cfg == 16'd0) ? SEQ_SELECT : SEQ_SETTLE;
                end
                else
                begin
                    busy = 1'b0;
                end
            end
        endcase
        beat.cs_n  = pin_cs_n;
        beat.sck   = pin_sck;
        beat.mosi  = pin_mosi;
        beat.busy  = busy;
        beat.done  = done;
        beat.x_avg = avg_x;
        beat.y_avg = avg_y;
    endtask

    // Report one field that differs from its prediction
    task automatic check_field(input string name, input logic [SAMPLE_W-1:0] want,
                               input logic [SAMPLE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Rising edge: take result beats, check them, then predict new ticks.
    // Checking comes first in the same process so the oldest expectation
    // is always the one popped, whatever order the edges resolve in.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : beat_checker
        pin_beat_t want_beat;
        pin_beat_t next_beat;
        in_taken  = in_valid && !in_stall;
        out_taken = out_valid && !out_stall;
        if (out_taken)
        begin
            beats_seen++;
            if (expected_beats.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                fail_count++;
            end
            else
            begin
                want_beat = expected_beats.pop_front();
                check_field("chip_select_n", SAMPLE_W'(want_beat.cs_n),
                            SAMPLE_W'(chip_select_n));
                check_field("serial_clock", SAMPLE_W'(want_beat.sck),
                            SAMPLE_W'(serial_clock));
                check_field("data_out_pin", SAMPLE_W'(want_beat.mosi),
                            SAMPLE_W'(data_out_pin));
                check_field("busy_res", SAMPLE_W'(want_beat.busy), SAMPLE_W'(busy_res));
                check_field("done_res", SAMPLE_W'(want_beat.done), SAMPLE_W'(done_res));
                check_field("x_average", want_beat.x_avg, x_average);
                check_field("y_average", want_beat.y_avg, y_average);
            end
        end
        if (in_taken)
        begin
            step_readout(start_req, data_in_pin, next_beat);
            expected_beats.push_back(next_beat);
        end
    end

    // ------------------------------------------------------------------
    // Driver: present ticks at the falling edge. Hold a stalled beat as
    // it is; once a beat goes, draw the gap before the next one.
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(negedge clk)
    begin : tick_driver
        tick_t next_tick;
        if (!in_valid || in_taken)
        begin
            if (in_taken)
                gap_left = $urandom_range(0, send_gap_max);
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_ticks.size() > 0)
            begin
                next_tick = pending_ticks.pop_front();
                start_req <= next_tick.start;
                data_in_pin <= next_tick.din;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall at the falling edge. A fresh hold token starts one
    // long hold-off, otherwise draw a short stall after each beat taken.
    // ------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (out_taken)
                stall_left = $urandom_range(0, recv_gap_max);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if it overstays the cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_tick(input logic start, input logic din);
        tick_t t;
        t.start = start;
        t.din = din;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // Idle ticks with no start request
    task automatic queue_idle(input int count);
        for (int i = 0; i < count; i++)
            push_tick(1'b0, 1'($urandom_range(0, 1)));
    endtask

    // One full measurement at the current settings: a start tick, then
    // exactly as many ticks as the sequence lasts, with start requests
    // sprinkled in (ignored while busy), then some idle ticks
    task automatic queue_measurement(input din_fill_t fill, input int trailing);
        int  body;
        int  read_bits;
        logic din;
        read_bits = long_read_cfg ? 12 : 8;
        body = int'(settle_cfg) + FRAMES * (FRAME_FIXED_TICKS + 2 * read_bits);
        push_tick(1'b1, 1'($urandom_range(0, 1)));
        for (int i = 0; i < body; i++)
        begin
            case (fill)
                DIN_ONES:  din = 1'b1;
                DIN_ZEROS: din = 1'b0;
                default:   din = 1'($urandom_range(0, 1));
            endcase
            push_tick(1'($urandom_range(0, 1)), din);
        end
        queue_idle(trailing);
    endtask

    // Register write on the plain port; mirror it in the model copy
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            tadc_pkg::REG_COMMAND_X:       cmd_x_cfg = val[7:0];
            tadc_pkg::REG_COMMAND_Y:       cmd_y_cfg = val[7:0];
            tadc_pkg::REG_TWELVE_BIT_MODE: long_read_cfg = val[0];
            default:                       settle_cfg = val;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold the sender back until every queued tick has its beat checked
    task automatic wait_drained();
        do
            @(negedge clk);
        while (beats_seen != ticks_queued);
        repeat (2) @(negedge clk);
    endtask

    // Draw a fresh setting for every register
    task automatic randomise_setup();
        write_reg(tadc_pkg::REG_COMMAND_X, CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(tadc_pkg::REG_COMMAND_Y, CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(tadc_pkg::REG_TWELVE_BIT_MODE, CFG_DATA_W'($urandom_range(0, 1)));
        write_reg(tadc_pkg::REG_SETTLE_TICKS,
                  CFG_DATA_W'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40)));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        reset_readout_model();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Idle ticks at the reset settings
        queue_idle(4);
        wait_drained();

        // Default commands and 12-bit reads with a short settle; full-scale
        // data so the sums reach their largest value
        write_reg(tadc_pkg::REG_SETTLE_TICKS, 16'd2);
        queue_measurement(DIN_ONES, 2);
        wait_drained();

        // No settling, 8-bit reads, command bytes at both extremes. The
        // sender runs flat out while the receiver holds off for a long
        // stretch, so the block backs up and stalls its input. Start again
        // on the tick right after done and stop part way through.
        write_reg(tadc_pkg::REG_SETTLE_TICKS, 16'd0);
        write_reg(tadc_pkg::REG_TWELVE_BIT_MODE, 16'd0);
        write_reg(tadc_pkg::REG_COMMAND_X, 16'h00FF);
        write_reg(tadc_pkg::REG_COMMAND_Y, 16'h0000);
        send_gap_max = 0;
        recv_gap_max = 0;
        @(posedge clk);
        hold_token++;
        queue_measurement(DIN_RANDOM, 0);
        push_tick(1'b1, 1'($urandom_range(0, 1)));
        queue_idle(100);
        wait_drained();

        // Random settings written while that measurement is still under
        // way; they take effect at once. Carry on for a while with idling
        // on both sides.
        send_gap_max = 7;
        recv_gap_max = 7;
        randomise_setup();
        push_tick(1'b1, 1'($urandom_range(0, 1)));
        queue_idle(150);
        wait_drained();

        // Let the pipeline settle, then settle the verdict
        repeat (4) @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            $error("%0d expected beats never arrived", expected_beats.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
